FILE: rtl/b64d_pkg.sv
// Shared types, constants and the alphabet lookup of the base64 stream decoder.
`default_nettype none
package b64d_pkg;

	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
	localparam logic [7:0] CHAR_DIG_0 = 8'h30;
	localparam logic [7:0] CHAR_DIG_9 = 8'h39;

	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;
	localparam logic [7:0] LO_OFFSET    = 8'd26;
	localparam logic [7:0] DIG_OFFSET   = 8'd52;

	localparam logic [15:0] COUNT_MAX = 16'hffff;

	typedef struct packed {
		logic [7:0] char_in;
		logic       restart;
		logic       chunk_last;
	} in_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  byte_out;
		logic        chunk_done;
		logic [15:0] chunk_bytes;
	} out_t;

	// Classified request as it travels through the queue.
	typedef struct packed {
		logic       sextet_ok;
		logic [5:0] sextet;
		logic       restart;
		logic       chunk_last;
	} cls_t;

	// Queue handshake between front end and queue.
	typedef struct packed {
		logic valid;
		logic ready;
	} qhs_t;

	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
			d = c - CHAR_UP_A;
			return {1'b1, d[5:0]};
		end
		if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
			d = c - CHAR_LO_A + LO_OFFSET;
			return {1'b1, d[5:0]};
		end
		if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
			d = c - CHAR_DIG_0 + DIG_OFFSET;
			return {1'b1, d[5:0]};
		end
		if (c == CHAR_PLUS) return {1'b1, SEXTET_PLUS};
		if (c == CHAR_SLASH) return {1'b1, SEXTET_SLASH};
		return {1'b0, d[5:0]};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/b64d_front.sv
// Front end: accepts characters and classifies them into sextets for the queue.
`default_nettype none
module b64d_front (
	input  wire            in_valid,
	output logic           in_ready,
	input  b64d_pkg::in_t  in_item,
	output b64d_pkg::qhs_t push,
	input  wire            push_ready,
	output b64d_pkg::cls_t push_item
);
	import b64d_pkg::*;

	logic [6:0] lookup;

	always_comb begin
		lookup               = sextet_of(in_item.char_in);
		push_item.sextet_ok  = lookup[6];
		push_item.sextet     = lookup[5:0];
		push_item.restart    = in_item.restart;
		push_item.chunk_last = in_item.chunk_last;
		push.valid           = in_valid;
		push.ready           = push_ready;
		in_ready             = push_ready;
	end

endmodule
`default_nettype wire

FILE: rtl/b64d_queue.sv
// Small FIFO that decouples the classifier from the byte assembler.
`default_nettype none
module b64d_queue #(
	parameter int DEPTH = 2
) (
	input  wire            clk,
	input  wire            arst_n,
	input  b64d_pkg::qhs_t push,
	input  b64d_pkg::cls_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	input  wire            pop_ready,
	output b64d_pkg::cls_t pop_item
);
	import b64d_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (fill_q != CW'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/b64d_back.sv
// Back end: four-phase byte assembly, chunk byte count and the output register.
`default_nettype none
module b64d_back (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            pop_valid,
	output logic           pop_ready,
	input  b64d_pkg::cls_t pop_item,
	output logic           out_valid,
	input  wire            out_ready,
	output b64d_pkg::out_t out_item
);
	import b64d_pkg::*;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;
	localparam logic [1:0] PH_FOURTH = 2'd3;

	logic [1:0]  phase_q;
	logic [7:0]  partial_q;
	logic [15:0] count_q;
	logic        out_valid_q;
	out_t        out_q;

	logic [1:0]  ph;
	logic [7:0]  pb;
	logic [15:0] cnt;
	logic [1:0]  ph_next;
	logic [7:0]  pb_next;
	logic [15:0] cnt_next;
	logic        bv;
	logic [7:0]  bo;
	logic [5:0]  v;
	logic        take;

	assign pop_ready = !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		// Restart clears the state before this character is applied.
		ph      = pop_item.restart ? PH_FIRST : phase_q;
		pb      = pop_item.restart ? 8'h00 : partial_q;
		cnt     = pop_item.restart ? 16'h0000 : count_q;
		v       = pop_item.sextet;
		ph_next = ph;
		pb_next = pb;
		bv      = 1'b0;
		bo      = 8'h00;
		if (pop_item.sextet_ok) begin
			ph_next = ph + 2'd1;
			unique case (ph)
				PH_FIRST: begin
					pb_next = {v, 2'b00};
				end
				PH_SECOND: begin
					bo      = pb | {6'b0, v[5:4]};
					pb_next = {v[3:0], 4'b0000};
					bv      = 1'b1;
				end
				PH_THIRD: begin
					bo      = pb | {4'b0, v[5:2]};
					pb_next = {v[1:0], 6'b000000};
					bv      = 1'b1;
				end
				PH_FOURTH: begin
					bo      = pb | {2'b0, v};
					pb_next = 8'h00;
					bv      = 1'b1;
				end
			endcase
		end
		cnt_next = (bv && cnt != COUNT_MAX) ? cnt + 16'd1 : cnt;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.byte_valid  <= bv;
			out_q.byte_out    <= bo;
			out_q.chunk_done  <= pop_item.chunk_last;
			out_q.chunk_bytes <= cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			partial_q   <= 8'h00;
			count_q     <= 16'h0000;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q     <= ph_next;
				partial_q   <= pb_next;
				// Drop the count at chunk end; phase and partial carry over.
				count_q     <= pop_item.chunk_last ? 16'h0000 : cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: classifier, queue and byte assembler.
// An accepted request is written into a queue slot, and is then taken by the
// assembler into the output register, from which its result is shown.
// Throughput: one character per cycle while the output is not stalled;
// the queue lets input and output stall independently.
// Reset (arst_n low, asynchronous): phase, partial byte and chunk count go to
// zero and the queue and output register empty.
`default_nettype none
module base64_stream_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  b64d_pkg::in_t  in_item,
	output logic           out_valid,
	input  wire            out_ready,
	output b64d_pkg::out_t out_item
);
	import b64d_pkg::*;

	qhs_t push;
	cls_t push_item;
	logic push_ready;
	logic pop_valid;
	logic pop_ready;
	cls_t pop_item;

	b64d_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire
